[design/cca_pkg.sv]
package cca_pkg;

  localparam int CHROMOSOMES = 2;
  localparam int POSITIONS   = 32768;

  localparam int CHROM_W       = 1;
  localparam int POS_W         = 15;
  localparam int LEN_W         = 28;
  localparam int CODE_W        = 4;
  localparam int DEPTH_W       = 16;
  localparam int CURSOR_W      = 32;
  localparam int ADDR_W        = CHROM_W + POS_W;
  localparam int DEPTH_ENTRIES = CHROMOSOMES * POSITIONS;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_HIGH   = 2'd2;

  localparam logic OP_ELEMENT = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  localparam logic [CODE_W-1:0] CIGAR_M  = 4'd0;
  localparam logic [CODE_W-1:0] CIGAR_I  = 4'd1;
  localparam logic [CODE_W-1:0] CIGAR_D  = 4'd2;
  localparam logic [CODE_W-1:0] CIGAR_N  = 4'd3;
  localparam logic [CODE_W-1:0] CIGAR_S  = 4'd4;
  localparam logic [CODE_W-1:0] CIGAR_H  = 4'd5;
  localparam logic [CODE_W-1:0] CIGAR_P  = 4'd6;
  localparam logic [CODE_W-1:0] CIGAR_EQ = 4'd7;
  localparam logic [CODE_W-1:0] CIGAR_X  = 4'd8;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef struct packed {
    logic              operation;
    logic              first_element;
    logic [CHROM_W-1:0] chromosome;
    logic [POS_W-1:0]  read_start;
    logic [CODE_W-1:0] cigar_code;
    logic [LEN_W-1:0]  cigar_length;
    logic [POS_W-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [CHROM_W-1:0] out_chromosome;
    logic [POS_W:0]     out_position;
    logic [DEPTH_W-1:0] depth;
    logic               covered;
  } out_item_t;

  typedef enum logic {
    CMD_SPAN = 1'b0,
    CMD_READ = 1'b1
  } cmd_kind_t;

  // A span covers positions lo up to hi - 1; a read-out uses lo as its position.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [CHROM_W-1:0] chrom;
    logic [POS_W-1:0]   lo;
    logic [POS_W:0]     hi;
    logic               hit;
  } cmd_t;

endpackage

[design/cca_front.sv]
module cca_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cca_pkg::in_item_t              in_data,
  input  logic                           cfg_we,
  input  logic [cca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cca_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           clearing,
  input  logic                           q_full,
  output logic                           q_push,
  output cca_pkg::cmd_t                  q_entry
);

  logic                          region_enable_r;
  logic [cca_pkg::POS_W-1:0]     region_low_r;
  logic [cca_pkg::POS_W-1:0]     region_high_r;
  logic [cca_pkg::CURSOR_W-1:0]  cursor_r;
  logic [cca_pkg::CURSOR_W-1:0]  cursor_nxt;
  logic [cca_pkg::CURSOR_W-1:0]  base;
  logic [cca_pkg::CURSOR_W:0]    sum;
  logic [cca_pkg::CURSOR_W:0]    lo_c;
  logic [cca_pkg::CURSOR_W:0]    hi_c;
  logic                          is_count;
  logic                          is_move;
  logic                          chrom_ok;
  logic                          pos_ok;
  logic                          span_ok;
  logic                          accept;

  assign in_ready = !clearing && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    base     = in_data.first_element ? cca_pkg::CURSOR_W'(in_data.read_start) : cursor_r;
    sum      = {1'b0, base} + (cca_pkg::CURSOR_W + 1)'(in_data.cigar_length);
    is_count = in_data.cigar_code inside {cca_pkg::CIGAR_M, cca_pkg::CIGAR_EQ, cca_pkg::CIGAR_X};
    is_move  = is_count ||
               (in_data.cigar_code inside {cca_pkg::CIGAR_D, cca_pkg::CIGAR_N, cca_pkg::CIGAR_P});
    chrom_ok = 32'(in_data.chromosome) < cca_pkg::CHROMOSOMES;
    pos_ok   = 32'(in_data.position) < cca_pkg::POSITIONS;

    // Clip the span to the window and, when enabled, to the region.
    lo_c = {1'b0, base};
    hi_c = (sum > (cca_pkg::CURSOR_W + 1)'(cca_pkg::POSITIONS)) ?
           (cca_pkg::CURSOR_W + 1)'(cca_pkg::POSITIONS) : sum;
    if (region_enable_r) begin
      if (lo_c < (cca_pkg::CURSOR_W + 1)'(region_low_r)) begin
        lo_c = (cca_pkg::CURSOR_W + 1)'(region_low_r);
      end
      if (hi_c > (cca_pkg::CURSOR_W + 1)'(region_high_r) + 1'b1) begin
        hi_c = (cca_pkg::CURSOR_W + 1)'(region_high_r) + 1'b1;
      end
    end
    span_ok = chrom_ok && (lo_c < hi_c);

    if (is_move) begin
      cursor_nxt = sum[cca_pkg::CURSOR_W] ? '1 : sum[cca_pkg::CURSOR_W-1:0];
    end else begin
      cursor_nxt = base;
    end

    q_entry.chrom = in_data.chromosome;
    if (in_data.operation == cca_pkg::OP_READOUT) begin
      q_entry.kind = cca_pkg::CMD_READ;
      q_entry.lo   = in_data.position;
      q_entry.hi   = '0;
      q_entry.hit  = chrom_ok && pos_ok;
      q_push       = accept;
    end else begin
      q_entry.kind = cca_pkg::CMD_SPAN;
      q_entry.lo   = lo_c[cca_pkg::POS_W-1:0];
      q_entry.hi   = hi_c[cca_pkg::POS_W:0];
      q_entry.hit  = 1'b1;
      q_push       = accept && is_count && span_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_enable_r <= 1'b0;
      region_low_r    <= '0;
      region_high_r   <= '1;
      cursor_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cca_pkg::CFG_REGION_ENABLE: region_enable_r <= cfg_data[0];
          cca_pkg::CFG_REGION_LOW:    region_low_r    <= cfg_data[cca_pkg::POS_W-1:0];
          cca_pkg::CFG_REGION_HIGH:   region_high_r   <= cfg_data[cca_pkg::POS_W-1:0];
          default: ;
        endcase
      end
      if (accept && in_data.operation == cca_pkg::OP_ELEMENT) begin
        cursor_r <= cursor_nxt;
      end
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !accept)
    else $error("item accepted during the clearing pass");

  a_span_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_entry.kind == cca_pkg::CMD_SPAN) |->
      ({1'b0, q_entry.lo} < q_entry.hi &&
       32'(q_entry.hi) <= cca_pkg::POSITIONS))
    else $error("queued span is empty or leaves the window");

endmodule

[design/cca_fifo.sv]
module cca_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cca_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output cca_pkg::cmd_t pop_data
);

  cca_pkg::cmd_t                   mem_r [cca_pkg::FIFO_DEPTH];
  logic [cca_pkg::FIFO_PTR_W-1:0]  wr_ptr_r;
  logic [cca_pkg::FIFO_PTR_W-1:0]  rd_ptr_r;
  logic [cca_pkg::FIFO_CNT_W-1:0]  count_r;
  logic                            do_push;
  logic                            do_pop;

  assign full      = count_r == cca_pkg::FIFO_CNT_W'(cca_pkg::FIFO_DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !pop_valid))
    else $error("command popped from an empty queue");

endmodule

[design/cca_back.sv]
module cca_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cca_pkg::cmd_t      q_entry,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output cca_pkg::out_item_t out_data
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SPAN  = 4'b0100,
    ST_READ  = 4'b1000
  } state_t;

  logic [cca_pkg::DEPTH_W-1:0] mem [cca_pkg::DEPTH_ENTRIES];
  logic [cca_pkg::DEPTH_W-1:0] rdata_r;

  state_t                       state_r, state_nxt;
  logic [cca_pkg::ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [cca_pkg::CHROM_W-1:0]  chrom_r, chrom_nxt;
  logic [cca_pkg::POS_W-1:0]    cur_r, cur_nxt;
  logic [cca_pkg::POS_W:0]      hi_r, hi_nxt;
  logic                         hit_r, hit_nxt;

  logic                         b_valid_r, b_valid_nxt;
  logic                         b_read_r, b_read_nxt;
  logic                         b_hit_r, b_hit_nxt;
  logic [cca_pkg::CHROM_W-1:0]  b_chrom_r, b_chrom_nxt;
  logic [cca_pkg::POS_W-1:0]    b_pos_r, b_pos_nxt;

  logic                         out_valid_r, out_valid_nxt;
  cca_pkg::out_item_t           out_data_r, out_data_nxt;

  logic                         rd_en;
  logic [cca_pkg::ADDR_W-1:0]   rd_addr;
  logic                         we;
  logic [cca_pkg::ADDR_W-1:0]   waddr;
  logic [cca_pkg::DEPTH_W-1:0]  wdata;
  logic [cca_pkg::DEPTH_W-1:0]  rd_depth;

  assign clearing  = state_r == ST_CLEAR;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Issue side: one memory read per cycle while a span is walked. A bubble in ST_IDLE between
  // commands lets the previous write land before the next read.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    chrom_nxt    = chrom_r;
    cur_nxt      = cur_r;
    hi_nxt       = hi_r;
    hit_nxt      = hit_r;
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = {chrom_r, cur_r};
    b_valid_nxt  = 1'b0;
    b_read_nxt   = 1'b0;
    b_hit_nxt    = hit_r;
    b_chrom_nxt  = chrom_r;
    b_pos_nxt    = cur_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          chrom_nxt = q_entry.chrom;
          cur_nxt   = q_entry.lo;
          hi_nxt    = q_entry.hi;
          hit_nxt   = q_entry.hit;
          state_nxt = (q_entry.kind == cca_pkg::CMD_READ) ? ST_READ : ST_SPAN;
        end
      end
      ST_SPAN: begin
        rd_en       = 1'b1;
        b_valid_nxt = 1'b1;
        cur_nxt     = cur_r + 1'b1;
        if ({1'b0, cur_r} + 1'b1 == hi_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        // The output register is free, so the result can land there from the update stage.
        if (!out_valid_r) begin
          rd_en       = hit_r;
          b_valid_nxt = 1'b1;
          b_read_nxt  = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Update side: clearing-pass writes, read-modify-write of the depth counter, or read-out and clear.
  always_comb begin
    rd_depth      = b_hit_r ? rdata_r : '0;
    we            = 1'b0;
    waddr         = {b_chrom_r, b_pos_r};
    wdata         = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_addr_r;
    end else if (b_valid_r && !b_read_r) begin
      we    = 1'b1;
      wdata = (rdata_r == cca_pkg::DEPTH_MAX) ? rdata_r : rdata_r + 1'b1;
    end else if (b_valid_r && b_read_r) begin
      we                          = b_hit_r;
      out_valid_nxt               = 1'b1;
      out_data_nxt.out_chromosome = b_chrom_r;
      out_data_nxt.out_position   = {1'b0, b_pos_r} + 1'b1;
      out_data_nxt.depth          = rd_depth;
      out_data_nxt.covered        = rd_depth != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chrom_r    <= chrom_nxt;
    cur_r      <= cur_nxt;
    hi_r       <= hi_nxt;
    hit_r      <= hit_nxt;
    b_read_r   <= b_read_nxt;
    b_hit_r    <= b_hit_nxt;
    b_chrom_r  <= b_chrom_nxt;
    b_pos_r    <= b_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  a_readout_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_read_r) |-> !out_valid_r)
    else $error("read-out reached the update stage with the output register full");

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (!b_valid_r && !q_pop))
    else $error("command processed during the clearing pass");

endmodule

[design/cigar_coverage_accumulator.sv]
// Path: a read-out item passes the queue, the back end's ST_IDLE and ST_READ states, the memory
// read, the update stage and the output register, and waits longer when spans wait ahead of it
// in the queue or an earlier result has not been taken. Throughput: the front end takes one item
// per cycle outside the clearing pass while its 4-entry queue has room; the back end walks a
// counted span one position per cycle through the read port and the write port of the depth
// memory, and spends no time on an element that only moves the cursor or does nothing.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all 65536 entries of the depth
// memory, with in_ready low throughout. Configuration writes are taken during that pass.
module cigar_coverage_accumulator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cca_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cca_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [cca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cca_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic          clearing;
  logic          q_full;
  logic          q_push;
  cca_pkg::cmd_t q_push_data;
  logic          q_pop;
  logic          q_valid;
  cca_pkg::cmd_t q_pop_data;

  cca_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_push_data)
  );

  cca_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_data (q_pop_data)
  );

  cca_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (q_pop_data),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

[verif/tb_cigar_coverage_accumulator.sv]
`timescale 1ns / 100ps

module tb_cigar_coverage_accumulator;
  import cca_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES    = 20;
  localparam int          IDLE_PCT        = 28;
  localparam int          ITEMS_PER_PHASE = 130;
  localparam int          PHASES          = 7;
  localparam int          HOT_SPAN        = 600;
  localparam int          LATE_START      = 32640;

  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [POS_W-1:0]  POS_LAST = '1;
  localparam logic [CODE_W-1:0] CIGAR_UNUSED_LO = CIGAR_X + 4'd1;
  localparam logic [CODE_W-1:0] CIGAR_UNUSED_HI = '1;
  localparam longint unsigned   CURSOR_SAT = 64'hFFFF_FFFF;

  // Mirrors the depth store and the reference cursor, and queues the
  // read-out results that the accepted items call for.
  class depth_predictor;
    logic [DEPTH_W-1:0]  depth_mem [DEPTH_ENTRIES];
    logic [CURSOR_W-1:0] cursor;
    logic                region_on;
    logic [POS_W-1:0]    region_lo;
    logic [POS_W-1:0]    region_hi;
    out_item_t           expected_readouts [$];
    int unsigned         mismatches;

    function new();
      foreach (depth_mem[i]) depth_mem[i] = '0;
      cursor     = '0;
      region_on  = 1'b0;
      region_lo  = '0;
      region_hi  = '1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_REGION_ENABLE: region_on = data[0];
        CFG_REGION_LOW:    region_lo = data[POS_W-1:0];
        CFG_REGION_HIGH:   region_hi = data[POS_W-1:0];
        default: ;
      endcase
    endfunction

    function void advance(logic [LEN_W-1:0] len);
      longint unsigned next_pos;
      next_pos = cursor;
      next_pos = next_pos + len;
      if (next_pos > CURSOR_SAT) next_pos = CURSOR_SAT;
      cursor = next_pos[CURSOR_W-1:0];
    endfunction

    function void count_span(logic [CHROM_W-1:0] chrom, logic [LEN_W-1:0] len);
      longint unsigned lo;
      longint unsigned hi;
      int unsigned     idx;
      lo = cursor;
      hi = lo + len;
      if (hi > POSITIONS) hi = POSITIONS;
      if (region_on) begin
        if (lo < region_lo) lo = region_lo;
        if (hi > longint'(region_hi) + 1) hi = longint'(region_hi) + 1;
      end
      for (longint unsigned p = lo; p < hi; p++) begin
        idx = int'(chrom) * POSITIONS + int'(p);
        if (depth_mem[idx] != DEPTH_MAX) depth_mem[idx] = depth_mem[idx] + 1'b1;
      end
    endfunction

    function void note_item(in_item_t it);
      out_item_t   exp;
      int unsigned idx;
      if (it.operation == OP_READOUT) begin
        idx                = {it.chromosome, it.position};
        exp.out_chromosome = it.chromosome;
        exp.out_position   = {1'b0, it.position} + 1'b1;
        exp.depth          = depth_mem[idx];
        exp.covered        = (depth_mem[idx] != '0);
        depth_mem[idx]     = '0;
        expected_readouts.push_back(exp);
      end else begin
        if (it.first_element) cursor = {{(CURSOR_W-POS_W){1'b0}}, it.read_start};
        case (it.cigar_code)
          CIGAR_M, CIGAR_EQ, CIGAR_X: begin
            count_span(it.chromosome, it.cigar_length);
            advance(it.cigar_length);
          end
          CIGAR_D, CIGAR_N, CIGAR_P: advance(it.cigar_length);
          default: ;
        endcase
      end
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
        mismatches++;
      end
    endfunction

    function void check_readout(out_item_t got);
      out_item_t exp;
      if (expected_readouts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual position %0d depth %0d",
                 $time, got.out_position, got.depth);
        mismatches++;
        return;
      end
      exp = expected_readouts.pop_front();
      compare_field("out_chromosome", exp.out_chromosome, got.out_chromosome);
      compare_field("out_position", exp.out_position, got.out_position);
      compare_field("depth", exp.depth, got.depth);
      compare_field("covered", exp.covered, got.covered);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  calm = 1'b0;
  int unsigned           stall_cycles = 0;
  depth_predictor        predictor;

  cigar_coverage_accumulator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready) predictor.check_readout(out_data);
  end

  // Covers the clearing pass after reset and the longest clipped span.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("cigar_coverage_accumulator regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_item_t element(logic first, logic [CHROM_W-1:0] chrom,
                                       logic [POS_W-1:0] start, logic [CODE_W-1:0] code,
                                       logic [LEN_W-1:0] len);
    logic [95:0] noise;
    in_item_t    it;
    noise            = {$urandom(), $urandom(), $urandom()};
    it               = noise[$bits(in_item_t)-1:0];
    it.operation     = OP_ELEMENT;
    it.first_element = first;
    it.chromosome    = chrom;
    it.read_start    = start;
    it.cigar_code    = code;
    it.cigar_length  = len;
    return it;
  endfunction

  function automatic in_item_t readout(logic [CHROM_W-1:0] chrom, logic [POS_W-1:0] pos);
    logic [95:0] noise;
    in_item_t    it;
    noise         = {$urandom(), $urandom(), $urandom()};
    it            = noise[$bits(in_item_t)-1:0];
    it.operation  = OP_READOUT;
    it.chromosome = chrom;
    it.position   = pos;
    return it;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    int unsigned r;
    int unsigned u;
    r = $urandom_range(0, 99);
    if (r < 35) return CIGAR_M;
    if (r < 43) return CIGAR_EQ;
    if (r < 50) return CIGAR_X;
    if (r < 58) return CIGAR_I;
    if (r < 66) return CIGAR_D;
    if (r < 72) return CIGAR_N;
    if (r < 79) return CIGAR_S;
    if (r < 86) return CIGAR_H;
    if (r < 93) return CIGAR_P;
    u = $urandom_range(CIGAR_UNUSED_LO, CIGAR_UNUSED_HI);
    return u[CODE_W-1:0];
  endfunction

  // Long match spans are only drawn where the window clips them to at most 128
  // positions, since the block walks a counted span one position per cycle.
  function automatic logic [LEN_W-1:0] pick_len(logic [CODE_W-1:0] code, logic [31:0] at);
    int unsigned r;
    logic [31:0] v;
    logic        is_match;
    r        = $urandom_range(0, 99);
    is_match = (code == CIGAR_M) || (code == CIGAR_EQ) || (code == CIGAR_X);
    if (!is_match && r < 12) v = $urandom();
    else if (is_match && at >= LATE_START && r < 30) v = $urandom();
    else if (r < 17) v = '0;
    else v = $urandom_range(1, 150);
    return v[LEN_W-1:0];
  endfunction

  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    predictor.note_item(it);
  endtask

  task automatic program_region(input logic en, input logic [POS_W-1:0] lo,
                                input logic [POS_W-1:0] hi);
    logic [31:0]           noise;
    logic [CFG_DATA_W-1:0] en_word;
    noise      = $urandom();
    en_word    = noise[CFG_DATA_W-1:0];
    en_word[0] = en;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REGION_ENABLE;
    cfg_data  <= en_word;
    predictor.write_reg(CFG_REGION_ENABLE, en_word);
    @(posedge clk);
    cfg_index <= CFG_REGION_LOW;
    cfg_data  <= lo;
    predictor.write_reg(CFG_REGION_LOW, lo);
    @(posedge clk);
    cfg_index <= CFG_REGION_HIGH;
    cfg_data  <= hi;
    predictor.write_reg(CFG_REGION_HIGH, hi);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // The closing read-out comes back only after every earlier span has been
  // walked, so the block is idle once the queue has drained.
  task automatic close_phase(input int base);
    logic [31:0] r;
    r = $urandom();
    send_item(readout(r[0], POS_W'(base)));
    in_valid <= 1'b0;
    while (predictor.expected_readouts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_read(input int base, inout int sent);
    logic [31:0]        r;
    logic [CHROM_W-1:0] chrom;
    logic [POS_W-1:0]   start;
    logic [CODE_W-1:0]  code;
    logic [LEN_W-1:0]   len;
    logic [31:0]        at;
    logic               started;
    logic               first;
    int unsigned        sel;
    int                 n_el;
    int                 n_ro;
    int                 p;
    r     = $urandom();
    chrom = r[0];
    sel   = $urandom_range(0, 99);
    if (sel < 6) start = r[POS_W:1];
    else if (sel < 10) start = POS_LAST - POS_W'($urandom_range(0, 127));
    else start = POS_W'(base + $urandom_range(0, HOT_SPAN));
    // A few reads arrive without a first element and pick up the old cursor.
    started = ($urandom_range(0, 99) >= 5);
    n_el    = $urandom_range(1, 8);
    for (int i = 0; i < n_el; i++) begin
      first = started && (i == 0);
      code  = pick_code();
      at    = first ? {{(32-POS_W){1'b0}}, start} : predictor.cursor;
      len   = pick_len(code, at);
      send_item(element(first, chrom, start, code, len));
      if (code inside {CIGAR_M, CIGAR_EQ, CIGAR_X, CIGAR_D, CIGAR_N, CIGAR_P}) sent++;
    end
    n_ro = $urandom_range(0, 3);
    for (int i = 0; i < n_ro; i++) begin
      r = $urandom();
      if ($urandom_range(0, 99) < 80) begin
        p = base + $urandom_range(0, HOT_SPAN + 200);
        if (p > POS_LAST) p = POS_LAST;
        send_item(readout(r[0], POS_W'(p)));
      end else begin
        send_item(readout(r[0], r[POS_W:1]));
      end
      sent++;
    end
  endtask

  task automatic directed_items();
    // A match before any read was started counts from the reset cursor.
    send_item(element(1'b0, 1'b1, '0, CIGAR_M, 28'd3));
    send_item(readout(1'b1, 15'd1));
    send_item(element(1'b1, 1'b0, '0, CIGAR_M, 28'd5));
    send_item(element(1'b0, 1'b0, '0, CIGAR_I, 28'd3));
    send_item(element(1'b0, 1'b0, '0, CIGAR_S, 28'd2));
    send_item(element(1'b0, 1'b0, '0, CIGAR_H, 28'd7));
    send_item(element(1'b0, 1'b0, '0, CIGAR_UNUSED_LO, 28'd5));
    send_item(element(1'b0, 1'b0, '0, CIGAR_UNUSED_HI, 28'd5));
    send_item(element(1'b0, 1'b0, '0, CIGAR_D, 28'd2));
    send_item(element(1'b0, 1'b0, '0, CIGAR_N, 28'd1));
    send_item(element(1'b0, 1'b0, '0, CIGAR_P, 28'd1));
    send_item(element(1'b0, 1'b0, '0, CIGAR_EQ, 28'd2));
    send_item(element(1'b0, 1'b0, '0, CIGAR_X, 28'd1));
    send_item(element(1'b0, 1'b0, '0, CIGAR_M, 28'd0));
    send_item(readout(1'b0, 15'd4));
    send_item(readout(1'b0, 15'd5));
    send_item(readout(1'b0, 15'd9));
    send_item(readout(1'b0, 15'd11));
    // The longest match, clipped by the end of the window to one position.
    send_item(element(1'b1, 1'b0, POS_LAST, CIGAR_M, LEN_MAX));
    send_item(readout(1'b0, POS_LAST));
    // Enough long deletions to drive the cursor into saturation.
    send_item(element(1'b1, 1'b0, POS_LAST, CIGAR_D, LEN_MAX));
    repeat (16) send_item(element(1'b0, 1'b0, '0, CIGAR_N, LEN_MAX));
    send_item(element(1'b0, 1'b0, '0, CIGAR_M, 28'd100));
    send_item(readout(1'b0, 15'd0));
  endtask

  initial begin
    int          base;
    int          sent;
    logic [31:0] r;
    predictor = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_region(1'b0, '0, POS_LAST);
    directed_items();
    close_phase(0);

    for (int ph = 0; ph < PHASES; ph++) begin
      base = $urandom_range(0, POS_LAST - HOT_SPAN);
      calm = (ph == 1);
      case (ph)
        0: program_region(1'b1, POS_W'(base + 100), POS_W'(base + 400));
        1: program_region(1'b1, '0, POS_LAST);
        2: program_region(1'b1, POS_W'(base + 300), POS_W'(base + 200));
        3: program_region(1'b1, POS_W'(base + 250), POS_W'(base + 250));
        4: begin
          r = $urandom();
          program_region(1'b0, r[POS_W-1:0], r[2*POS_W-1:POS_W]);
        end
        5: begin
          base = POS_LAST - HOT_SPAN;
          program_region(1'b1, POS_LAST, POS_LAST);
        end
        default: program_region(1'b0, '0, POS_LAST);
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) random_read(base, sent);
      close_phase(base);
    end

    if (predictor.mismatches == 0) begin
      $display("cigar_coverage_accumulator regression: pass");
    end else begin
      $display("cigar_coverage_accumulator regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
design/cca_pkg.sv
design/cca_front.sv
design/cca_fifo.sv
design/cca_back.sv
design/cigar_coverage_accumulator.sv
verif/tb_cigar_coverage_accumulator.sv
